// ----- src/circumcircle_from_three_points_core_defines.svh -----
// Assertion macros shared by the circumcircle core checker.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef CIRCUMCIRCLE_FROM_THREE_POINTS_CORE_DEFINES_SVH
`define CIRCUMCIRCLE_FROM_THREE_POINTS_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("circumcircle core check failed");

// The consequent must hold in the cycle after the antecedent.
`define CCFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("circumcircle core check failed");

`endif

// ----- src/ccfp_pkg.sv -----
// Shared constants of the circumcircle core.
// Used by the top level and by the port checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ccfp_pkg;

   localparam int OUT_BITS = 48;
   localparam int THR_BITS = 37;
   localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(1);
   // Offsets at or above this power of two force a saturated radius.
   localparam int ROOT_SAT_BIT = 62;

endpackage

`default_nettype wire

// ----- src/ccfp_div_cell.sv -----
// One quotient bit of the restoring divider chain, for the x and y lanes.
// Both lanes share the divisor; depends on no package.
`timescale 1ns / 1ps
`default_nettype none

module ccfp_div_cell #(
   parameter int RW    = 70,
   parameter int DW    = 36,
   parameter int QW    = 50,
   parameter int SHIFT = 0
) (
   input  logic          clock,
   input  logic          en,
   input  logic [RW-1:0] rx_in_d,
   input  logic [RW-1:0] ry_in_d,
   input  logic [DW-1:0] d_in_d,
   input  logic [QW-1:0] qx_in_d,
   input  logic [QW-1:0] qy_in_d,
   output logic [RW-1:0] rx_out,
   output logic [RW-1:0] ry_out,
   output logic [DW-1:0] d_out,
   output logic [QW-1:0] qx_out,
   output logic [QW-1:0] qy_out
);

   logic [RW-1:0] rx_ff, ry_ff, rx_in, ry_in, dsh;
   logic [DW-1:0] d_ff;
   logic [QW-1:0] qx_ff, qy_ff, qx_in, qy_in;
   logic          gex, gey;

   always_comb begin
      // Comparing the remainder shifted down avoids a divisor wider than the remainder.
      dsh   = RW'(d_in_d) << SHIFT;
      gex   = (rx_in_d >> SHIFT) >= RW'(d_in_d);
      gey   = (ry_in_d >> SHIFT) >= RW'(d_in_d);
      rx_in = gex ? (rx_in_d - dsh) : rx_in_d;
      ry_in = gey ? (ry_in_d - dsh) : ry_in_d;
      qx_in = {qx_in_d[QW-2:0], gex};
      qy_in = {qy_in_d[QW-2:0], gey};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         d_ff  <= d_in_d;
         qx_ff <= qx_in;
         qy_ff <= qy_in;
      end
   end

   assign rx_out = rx_ff;
   assign ry_out = ry_ff;
   assign d_out  = d_ff;
   assign qx_out = qx_ff;
   assign qy_out = qy_ff;

endmodule

`default_nettype wire

// ----- src/ccfp_root_cell.sv -----
// One result bit of the digit-by-digit square root chain.
// Holds the running remainder and partial root; depends on no package.
`timescale 1ns / 1ps
`default_nettype none

module ccfp_root_cell #(
   parameter int VW     = 100,
   parameter int BITPOS = 0
) (
   input  logic          clock,
   input  logic          en,
   input  logic [VW-1:0] v_in_d,
   input  logic [VW-1:0] res_in_d,
   output logic [VW-1:0] v_out,
   output logic [VW-1:0] res_out
);

   localparam logic [VW-1:0] BIT = VW'(1) << BITPOS;

   logic [VW-1:0] v_ff, res_ff, v_in, res_in, t, res_sh;
   logic          ge;

   always_comb begin
      t      = res_in_d + BIT;
      res_sh = res_in_d >> 1;
      ge     = v_in_d >= t;
      v_in   = ge ? (v_in_d - t) : v_in_d;
      res_in = ge ? (res_sh + BIT) : res_sh;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff   <= v_in;
         res_ff <= res_in;
      end
   end

   assign v_out   = v_ff;
   assign res_out = res_ff;

endmodule

`default_nettype wire

// ----- src/circumcircle_from_three_points_core.sv -----
// Circumcircle core: takes three integer points per beat and returns the circle center in
// signed fixed point and the radius, measured from the second point, in unsigned fixed
// point, both with FRAC_BITS fraction bits in 48-bit fields. Points whose scaled determinant
// magnitude is below the threshold register (or zero) come back flagged degenerate with
// zero fields; out-of-range results are clamped and flagged saturated. The core is fully
// pipelined and takes one beat per cycle while rsp_stall does not hold it. Each beat passes
// through the divider chain of one cell per quotient bit and then the root chain of one
// cell per result bit. The whole pipeline holds while a finished beat waits on rsp_stall.
// Depends on ccfp_pkg, ccfp_div_cell and ccfp_root_cell.
`timescale 1ns / 1ps
`default_nettype none

module circumcircle_from_three_points_core #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [ccfp_pkg::THR_BITS-1:0]          csr_wr_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COORD_BITS-1:0]           req_ax,
   input  logic signed [COORD_BITS-1:0]           req_ay,
   input  logic signed [COORD_BITS-1:0]           req_bx,
   input  logic signed [COORD_BITS-1:0]           req_by_coord,
   input  logic signed [COORD_BITS-1:0]           req_cx,
   input  logic signed [COORD_BITS-1:0]           req_cy,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ccfp_pkg::OUT_BITS-1:0]   rsp_center_x,
   output logic signed [ccfp_pkg::OUT_BITS-1:0]   rsp_center_y,
   output logic [ccfp_pkg::OUT_BITS-1:0]          rsp_radius,
   output logic                                   rsp_degenerate,
   output logic                                   rsp_saturated
);

   import ccfp_pkg::*;

   localparam int DIFW = COORD_BITS + 1;
   localparam int PRODW = 2 * DIFW;
   localparam int DETW = PRODW + 1;
   localparam int NPW = DETW + DIFW;
   localparam int NUMW = NPW + 1;
   localparam int DENW = DETW + 1;
   localparam int RW = NUMW + FRAC_BITS + 1;
   localparam int QB = OUT_BITS + 1;
   localparam int QW = QB + 1;
   localparam int NDIV = QB + 1;
   localparam int CMPW = (DETW + 2 > THR_BITS) ? DETW + 2 : THR_BITS;
   localparam int SHW = COORD_BITS + FRAC_BITS;
   localparam int EW = ((SHW > OUT_BITS) ? SHW : OUT_BITS) + 1;
   localparam int MW = (EW < ROOT_SAT_BIT) ? EW : ROOT_SAT_BIT;
   localparam int H = (MW + 1) / 2;
   localparam int HI = MW - H;
   localparam int SQW = 2 * MW;
   localparam int VW = 2 * MW + 2;
   localparam int RB = MW + 1;
   localparam int PIPE_LEN = 6 + NDIV + 7 + RB + 1;

   typedef struct packed {
      logic                         negx;
      logic                         negy;
      logic                         degen;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by;
   } div_side_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] qx;
      logic signed [OUT_BITS-1:0] qy;
      logic                       sat;
      logic                       degen;
      logic                       radbig;
   } root_side_type;

   logic                adv;
   logic [THR_BITS-1:0] thr_ff;
   logic [PIPE_LEN-1:0] vld_ff;
   logic                rsp_valid_ff;

   // The pipeline moves whenever the output register is free or being emptied.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THR_RESET;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         if (adv) begin
            vld_ff       <= {vld_ff[PIPE_LEN-2:0], req_valid};
            rsp_valid_ff <= vld_ff[PIPE_LEN-1];
         end
      end
   end

   // Stage 1: edge vectors and coordinate sums.
   logic signed [DIFW-1:0]       ux1_ff, uy1_ff, vx1_ff, vy1_ff;
   logic signed [DIFW-1:0]       sbx1_ff, sby1_ff, scx1_ff, scy1_ff;
   logic signed [COORD_BITS-1:0] bx1_ff, by1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ux1_ff  <= DIFW'(req_bx) - DIFW'(req_ax);
         uy1_ff  <= DIFW'(req_by_coord) - DIFW'(req_ay);
         vx1_ff  <= DIFW'(req_cx) - DIFW'(req_ax);
         vy1_ff  <= DIFW'(req_cy) - DIFW'(req_ay);
         sbx1_ff <= DIFW'(req_bx) + DIFW'(req_ax);
         sby1_ff <= DIFW'(req_by_coord) + DIFW'(req_ay);
         scx1_ff <= DIFW'(req_cx) + DIFW'(req_ax);
         scy1_ff <= DIFW'(req_cy) + DIFW'(req_ay);
         bx1_ff  <= req_bx;
         by1_ff  <= req_by_coord;
      end
   end

   // Stage 2: first products.
   logic signed [PRODW-1:0]      m_uv_ff, m_vu_ff, m_b1_ff, m_b2_ff, m_c1_ff, m_c2_ff;
   logic signed [DIFW-1:0]       ux2_ff, uy2_ff, vx2_ff, vy2_ff;
   logic signed [COORD_BITS-1:0] bx2_ff, by2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m_uv_ff <= PRODW'(ux1_ff) * PRODW'(vy1_ff);
         m_vu_ff <= PRODW'(vx1_ff) * PRODW'(uy1_ff);
         m_b1_ff <= PRODW'(ux1_ff) * PRODW'(sbx1_ff);
         m_b2_ff <= PRODW'(uy1_ff) * PRODW'(sby1_ff);
         m_c1_ff <= PRODW'(vx1_ff) * PRODW'(scx1_ff);
         m_c2_ff <= PRODW'(vy1_ff) * PRODW'(scy1_ff);
         ux2_ff  <= ux1_ff;
         uy2_ff  <= uy1_ff;
         vx2_ff  <= vx1_ff;
         vy2_ff  <= vy1_ff;
         bx2_ff  <= bx1_ff;
         by2_ff  <= by1_ff;
      end
   end

   // Stage 3: determinant and the squared-length differences.
   logic signed [DETW-1:0]       det3_ff, sb3_ff, sc3_ff;
   logic signed [DIFW-1:0]       ux3_ff, uy3_ff, vx3_ff, vy3_ff;
   logic signed [COORD_BITS-1:0] bx3_ff, by3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         det3_ff <= DETW'(m_uv_ff) - DETW'(m_vu_ff);
         sb3_ff  <= DETW'(m_b1_ff) + DETW'(m_b2_ff);
         sc3_ff  <= DETW'(m_c1_ff) + DETW'(m_c2_ff);
         ux3_ff  <= ux2_ff;
         uy3_ff  <= uy2_ff;
         vx3_ff  <= vx2_ff;
         vy3_ff  <= vy2_ff;
         bx3_ff  <= bx2_ff;
         by3_ff  <= by2_ff;
      end
   end

   // Stage 4: numerator products and the collinearity test.
   logic signed [NPW-1:0]        n1_ff, n2_ff, n3_ff, n4_ff;
   logic signed [DETW-1:0]       det4_ff;
   logic                         degen4_ff, degen4_in;
   logic [DETW-1:0]              det_mag;
   logic [CMPW-1:0]              det_mag4;
   logic signed [COORD_BITS-1:0] bx4_ff, by4_ff;

   always_comb begin
      det_mag   = det3_ff[DETW-1] ? DETW'(-det3_ff) : DETW'(det3_ff);
      det_mag4  = CMPW'(det_mag) << 2;
      degen4_in = (det3_ff == '0) || (det_mag4 < CMPW'(thr_ff));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_ff     <= NPW'(sb3_ff) * NPW'(vy3_ff);
         n2_ff     <= NPW'(sc3_ff) * NPW'(uy3_ff);
         n3_ff     <= NPW'(sc3_ff) * NPW'(ux3_ff);
         n4_ff     <= NPW'(sb3_ff) * NPW'(vx3_ff);
         det4_ff   <= det3_ff;
         degen4_ff <= degen4_in;
         bx4_ff    <= bx3_ff;
         by4_ff    <= by3_ff;
      end
   end

   // Stage 5: center numerators and twice the determinant.
   logic signed [NUMW-1:0]       nx5_ff, ny5_ff;
   logic signed [DENW-1:0]       den5_ff;
   logic                         degen5_ff;
   logic signed [COORD_BITS-1:0] bx5_ff, by5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         nx5_ff    <= NUMW'(n1_ff) - NUMW'(n2_ff);
         ny5_ff    <= NUMW'(n3_ff) - NUMW'(n4_ff);
         den5_ff   <= {det4_ff, 1'b0};
         degen5_ff <= degen4_ff;
         bx5_ff    <= bx4_ff;
         by5_ff    <= by4_ff;
      end
   end

   // Stage 6: magnitudes and signs for the divider; the numerator gets the
   // fraction bits plus one extra bit for rounding.
   logic [RW-1:0]   rx6_ff, ry6_ff;
   logic [DENW-1:0] d6_ff;
   logic [NUMW-1:0] nx_mag, ny_mag;
   div_side_type    side6_ff;

   always_comb begin
      nx_mag = nx5_ff[NUMW-1] ? NUMW'(-nx5_ff) : NUMW'(nx5_ff);
      ny_mag = ny5_ff[NUMW-1] ? NUMW'(-ny5_ff) : NUMW'(ny5_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rx6_ff         <= RW'(nx_mag) << (FRAC_BITS + 1);
         ry6_ff         <= RW'(ny_mag) << (FRAC_BITS + 1);
         d6_ff          <= den5_ff[DENW-1] ? DENW'(-den5_ff) : DENW'(den5_ff);
         side6_ff.negx  <= nx5_ff[NUMW-1] ^ den5_ff[DENW-1];
         side6_ff.negy  <= ny5_ff[NUMW-1] ^ den5_ff[DENW-1];
         side6_ff.degen <= degen5_ff;
         side6_ff.bx    <= bx5_ff;
         side6_ff.by    <= by5_ff;
      end
   end

   // Divider chain: the first cell finds the overflow bit, then one quotient bit per cell.
   logic [RW-1:0]   drx [0:NDIV];
   logic [RW-1:0]   dry [0:NDIV];
   logic [DENW-1:0] dd  [0:NDIV];
   logic [QW-1:0]   dqx [0:NDIV];
   logic [QW-1:0]   dqy [0:NDIV];
   div_side_type    dside_ff [0:NDIV-1];

   assign drx[0] = rx6_ff;
   assign dry[0] = ry6_ff;
   assign dd[0]  = d6_ff;
   assign dqx[0] = '0;
   assign dqy[0] = '0;

   for (genvar i = 0; i < NDIV; i++) begin : g_div
      ccfp_div_cell #(
         .RW(RW), .DW(DENW), .QW(QW), .SHIFT(QB - i)
      ) u_cell (
         .clock(clock), .en(adv),
         .rx_in_d(drx[i]), .ry_in_d(dry[i]), .d_in_d(dd[i]),
         .qx_in_d(dqx[i]), .qy_in_d(dqy[i]),
         .rx_out(drx[i+1]), .ry_out(dry[i+1]), .d_out(dd[i+1]),
         .qx_out(dqx[i+1]), .qy_out(dqy[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dside_ff[0] <= side6_ff;
         for (int i = 1; i < NDIV; i++) begin
            dside_ff[i] <= dside_ff[i-1];
         end
      end
   end

   // Final stage 1: round half away from zero and clamp the magnitudes.
   logic [QW-1:0]   qfx, qfy;
   logic [QB:0]     incx, incy;
   logic [QB-1:0]   magx, magy, limx, limy;
   logic            satx, saty;
   logic [QB-1:0]   magx1_ff, magy1_ff;
   logic            sat1_ff;
   div_side_type    side1_ff;

   always_comb begin
      qfx  = dqx[NDIV];
      qfy  = dqy[NDIV];
      incx = {1'b0, qfx[QB-1:0]} + (QB+1)'(1);
      incy = {1'b0, qfy[QB-1:0]} + (QB+1)'(1);
      magx = incx[QB:1];
      magy = incy[QB:1];
      limx = dside_ff[NDIV-1].negx ? (QB'(1) << (OUT_BITS - 1))
                                   : ((QB'(1) << (OUT_BITS - 1)) - QB'(1));
      limy = dside_ff[NDIV-1].negy ? (QB'(1) << (OUT_BITS - 1))
                                   : ((QB'(1) << (OUT_BITS - 1)) - QB'(1));
      satx = qfx[QB] || (magx > limx);
      saty = qfy[QB] || (magy > limy);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         magx1_ff <= satx ? limx : magx;
         magy1_ff <= saty ? limy : magy;
         sat1_ff  <= satx || saty;
         side1_ff <= dside_ff[NDIV-1];
      end
   end

   // Final stage 2: signed centers.
   logic signed [OUT_BITS-1:0]   qx2_ff, qy2_ff;
   logic                         sat2_ff, degen2_ff;
   logic signed [COORD_BITS-1:0] bxf2_ff, byf2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         qx2_ff    <= side1_ff.negx ? -OUT_BITS'(magx1_ff) : OUT_BITS'(magx1_ff);
         qy2_ff    <= side1_ff.negy ? -OUT_BITS'(magy1_ff) : OUT_BITS'(magy1_ff);
         sat2_ff   <= sat1_ff;
         degen2_ff <= side1_ff.degen;
         bxf2_ff   <= side1_ff.bx;
         byf2_ff   <= side1_ff.by;
      end
   end

   // Final stage 3: offsets from the second point to the rounded center.
   logic signed [EW-1:0]       ex3_ff, ey3_ff;
   logic signed [OUT_BITS-1:0] qx3_ff, qy3_ff;
   logic                       sat3_ff, degen3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ex3_ff    <= (EW'(bxf2_ff) <<< FRAC_BITS) - EW'(qx2_ff);
         ey3_ff    <= (EW'(byf2_ff) <<< FRAC_BITS) - EW'(qy2_ff);
         qx3_ff    <= qx2_ff;
         qy3_ff    <= qy2_ff;
         sat3_ff   <= sat2_ff;
         degen3_ff <= degen2_ff;
      end
   end

   // Final stage 4: offset magnitudes.
   logic [EW-1:0]              eax, eay;
   logic [MW-1:0]              emx4_ff, emy4_ff;
   logic                       radbig4_ff;
   logic signed [OUT_BITS-1:0] qx4_ff, qy4_ff;
   logic                       sat4_ff, degen4f_ff;

   always_comb begin
      eax = ex3_ff[EW-1] ? EW'(-ex3_ff) : EW'(ex3_ff);
      eay = ey3_ff[EW-1] ? EW'(-ey3_ff) : EW'(ey3_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         emx4_ff    <= MW'(eax);
         emy4_ff    <= MW'(eay);
         radbig4_ff <= ((eax >> ROOT_SAT_BIT) != '0) || ((eay >> ROOT_SAT_BIT) != '0);
         qx4_ff     <= qx3_ff;
         qy4_ff     <= qy3_ff;
         sat4_ff    <= sat3_ff;
         degen4f_ff <= degen3_ff;
      end
   end

   // Final stage 5: partial products of the squares, split into halves.
   logic [2*HI-1:0] px11_ff, py11_ff;
   logic [MW-1:0]   px10_ff, py10_ff;
   logic [2*H-1:0]  px00_ff, py00_ff;
   root_side_type   side5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         px11_ff         <= (2*HI)'(emx4_ff[MW-1:H]) * (2*HI)'(emx4_ff[MW-1:H]);
         px10_ff         <= MW'(emx4_ff[MW-1:H]) * MW'(emx4_ff[H-1:0]);
         px00_ff         <= (2*H)'(emx4_ff[H-1:0]) * (2*H)'(emx4_ff[H-1:0]);
         py11_ff         <= (2*HI)'(emy4_ff[MW-1:H]) * (2*HI)'(emy4_ff[MW-1:H]);
         py10_ff         <= MW'(emy4_ff[MW-1:H]) * MW'(emy4_ff[H-1:0]);
         py00_ff         <= (2*H)'(emy4_ff[H-1:0]) * (2*H)'(emy4_ff[H-1:0]);
         side5_ff.qx     <= qx4_ff;
         side5_ff.qy     <= qy4_ff;
         side5_ff.sat    <= sat4_ff;
         side5_ff.degen  <= degen4f_ff;
         side5_ff.radbig <= radbig4_ff;
      end
   end

   // Final stage 6: the squares; stage 7: their sum.
   logic [SQW-1:0] sqx6_ff, sqy6_ff;
   logic [VW-1:0]  v7_ff;
   root_side_type  side6r_ff, side7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx6_ff   <= (SQW'(px11_ff) << (2*H)) + (SQW'(px10_ff) << (H + 1)) + SQW'(px00_ff);
         sqy6_ff   <= (SQW'(py11_ff) << (2*H)) + (SQW'(py10_ff) << (H + 1)) + SQW'(py00_ff);
         side6r_ff <= side5_ff;
         v7_ff     <= VW'(sqx6_ff) + VW'(sqy6_ff);
         side7_ff  <= side6r_ff;
      end
   end

   // Root chain: one result bit per cell, from the top.
   logic [VW-1:0] rv [0:RB];
   logic [VW-1:0] rr [0:RB];
   root_side_type rside_ff [0:RB-1];

   assign rv[0] = v7_ff;
   assign rr[0] = '0;

   for (genvar i = 0; i < RB; i++) begin : g_root
      ccfp_root_cell #(
         .VW(VW), .BITPOS(2 * (RB - 1 - i))
      ) u_cell (
         .clock(clock), .en(adv),
         .v_in_d(rv[i]), .res_in_d(rr[i]),
         .v_out(rv[i+1]), .res_out(rr[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rside_ff[0] <= side7_ff;
         for (int i = 1; i < RB; i++) begin
            rside_ff[i] <= rside_ff[i-1];
         end
      end
   end

   // Round the root: step up when the remainder exceeds the root.
   logic [VW-1:0] rad_ff;
   root_side_type rads_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff  <= rr[RB] + VW'(rr[RB] < rv[RB]);
         rads_ff <= rside_ff[RB-1];
      end
   end

   // Output register.
   logic                       radover;
   logic signed [OUT_BITS-1:0] cx_ff, cy_ff;
   logic [OUT_BITS-1:0]        radius_ff;
   logic                       degen_ff, sat_ff;

   assign radover = rads_ff.radbig || ((rad_ff >> OUT_BITS) != '0);

   always_ff @(posedge clock) begin
      if (adv) begin
         if (rads_ff.degen) begin
            cx_ff     <= '0;
            cy_ff     <= '0;
            radius_ff <= '0;
            degen_ff  <= 1'b1;
            sat_ff    <= 1'b0;
         end else begin
            cx_ff     <= rads_ff.qx;
            cy_ff     <= rads_ff.qy;
            radius_ff <= radover ? '1 : OUT_BITS'(rad_ff);
            degen_ff  <= 1'b0;
            sat_ff    <= rads_ff.sat || radover;
         end
      end
   end

   assign rsp_center_x   = cx_ff;
   assign rsp_center_y   = cy_ff;
   assign rsp_radius     = radius_ff;
   assign rsp_degenerate = degen_ff;
   assign rsp_saturated  = sat_ff;

endmodule

`default_nettype wire

// ----- src/ccfp_checker.sv -----
// Port-level checks for the circumcircle core, bound to the top level.
// Depends on ccfp_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "circumcircle_from_three_points_core_defines.svh"

module ccfp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [ccfp_pkg::OUT_BITS-1:0] rsp_center_x,
   input logic signed [ccfp_pkg::OUT_BITS-1:0] rsp_center_y,
   input logic [ccfp_pkg::OUT_BITS-1:0]        rsp_radius,
   input logic                                 rsp_degenerate,
   input logic                                 rsp_saturated
);

   import ccfp_pkg::*;

   // The input side only backs up when a finished beat is held at the output.
   `CCFP_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall, rsp_valid && rsp_stall)

   // A degenerate beat carries all-zero fields and no saturation.
   `CCFP_ASSERT_NOW(a_degen_zero, clock, reset, rsp_valid && rsp_degenerate, (rsp_center_x == '0) && (rsp_center_y == '0) && (rsp_radius == '0) && !rsp_saturated)

   `CCFP_ASSERT_NEXT(a_rsp_hold_valid, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   `CCFP_ASSERT_NEXT(a_rsp_hold_data, clock, reset, rsp_valid && rsp_stall, $stable(rsp_radius) && $stable(rsp_center_x) && $stable(rsp_center_y))

endmodule

bind circumcircle_from_three_points_core ccfp_checker u_ccfp_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_center_x(rsp_center_x),
   .rsp_center_y(rsp_center_y),
   .rsp_radius(rsp_radius),
   .rsp_degenerate(rsp_degenerate),
   .rsp_saturated(rsp_saturated)
);

`default_nettype wire

// ----- tb/circumcircle_checker.sv -----
// Port checker for the circumcircle core: snoops the threshold register and both channels.
// It predicts each beat's circle and compares it with the result beats in order.
// Depends on ccfp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

module circumcircle_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [ccfp_pkg::THR_BITS-1:0]        csr_wr_data,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic signed [15:0]                   req_ax,
   input  logic signed [15:0]                   req_ay,
   input  logic signed [15:0]                   req_bx,
   input  logic signed [15:0]                   req_by_coord,
   input  logic signed [15:0]                   req_cx,
   input  logic signed [15:0]                   req_cy,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [ccfp_pkg::OUT_BITS-1:0] rsp_center_x,
   input  logic signed [ccfp_pkg::OUT_BITS-1:0] rsp_center_y,
   input  logic [ccfp_pkg::OUT_BITS-1:0]        rsp_radius,
   input  logic                                 rsp_degenerate,
   input  logic                                 rsp_saturated,
   output int                                   errors,
   output int                                   pending
);
   import ccfp_pkg::*;

   localparam int FRAC = 16;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] center_x;
      logic signed [OUT_BITS-1:0] center_y;
      logic [OUT_BITS-1:0]        radius;
      logic                       degenerate;
      logic                       saturated;
   } circle_type;

   circle_type circle_queue[$];
   logic [THR_BITS-1:0] threshold;

   // Rounded quotient num * 2^FRAC / den, ties away from zero, clamped to the output range.
   function automatic logic signed [OUT_BITS-1:0] scaled_quotient(
      input logic signed [127:0] num, input logic signed [127:0] den, inout logic sat);
      logic neg;
      logic [127:0] n, d, q, mag, lim;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = (n << (FRAC + 1)) / d;
      mag = (q + 1) >> 1;
      lim = neg ? (128'd1 << (OUT_BITS - 1)) : ((128'd1 << (OUT_BITS - 1)) - 1);
      if (mag > lim) begin
         mag = lim;
         sat = 1'b1;
      end
      return neg ? OUT_BITS'(-mag) : OUT_BITS'(mag);
   endfunction

   function automatic circle_type predict_circle(
      input logic signed [15:0] ax, ay, bx, by, cx, cy, input logic [THR_BITS-1:0] thr);
      circle_type c;
      logic signed [127:0] pax, pay, pbx, pby, pcx, pcy, ux, uy, vx, vy;
      logic signed [127:0] det, sb, sc, nx, ny, ex, ey;
      logic [127:0] mag4, v, res, t, rem;
      logic sat;
      pax = ax; pay = ay; pbx = bx; pby = by; pcx = cx; pcy = cy;
      ux = pbx - pax; uy = pby - pay; vx = pcx - pax; vy = pcy - pay;
      det = ux * vy - vx * uy;
      mag4 = ((det < 0) ? -det : det) << 2;
      c = '0;
      if (det == 0 || mag4 < {91'd0, thr}) begin
         c.degenerate = 1'b1;
         return c;
      end
      sat = 1'b0;
      sb = ux * (pbx + pax) + uy * (pby + pay);
      sc = vx * (pcx + pax) + vy * (pcy + pay);
      nx = sb * vy - sc * uy;
      ny = sc * ux - sb * vx;
      c.center_x = scaled_quotient(nx, det <<< 1, sat);
      c.center_y = scaled_quotient(ny, det <<< 1, sat);
      // The radius is measured from B to the already rounded center.
      ex = (pbx <<< FRAC) - c.center_x;
      ey = (pby <<< FRAC) - c.center_y;
      if (ex < 0) ex = -ex;
      if (ey < 0) ey = -ey;
      if (ex >= (128'sd1 <<< ROOT_SAT_BIT) || ey >= (128'sd1 <<< ROOT_SAT_BIT)) begin
         c.radius = '1;
         sat = 1'b1;
      end else begin
         v = ex * ex + ey * ey;
         res = 0;
         for (int b = 63; b >= 0; b--) begin
            t = res | (128'd1 << b);
            if (t * t <= v) res = t;
         end
         rem = v - res * res;
         if (res < rem) res = res + 1;
         if (res > {80'd0, {OUT_BITS{1'b1}}}) begin
            res = {80'd0, {OUT_BITS{1'b1}}};
            sat = 1'b1;
         end
         c.radius = res[OUT_BITS-1:0];
      end
      c.saturated = sat;
      return c;
   endfunction

   assign pending = circle_queue.size();

   always @(posedge clock) begin
      circle_type got, want;
      if (reset) begin
         threshold <= THR_RESET;
         errors <= 0;
      end else begin
         if (csr_wr_en) threshold <= csr_wr_data;
         if (req_valid && !req_stall)
            circle_queue.push_back(predict_circle(req_ax, req_ay, req_bx, req_by_coord,
                                                  req_cx, req_cy, threshold));
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_center_x, rsp_center_y, rsp_radius, rsp_degenerate, rsp_saturated};
            if (circle_queue.size() == 0) begin
               $display("%0t: result beat with nothing expected: %h", $realtime, got);
               errors <= errors + 1;
            end else begin
               want = circle_queue.pop_front();
               if (got.center_x !== want.center_x)
                  $display("%0t: center_x expected %0d actual %0d", $realtime,
                           want.center_x, got.center_x);
               if (got.center_y !== want.center_y)
                  $display("%0t: center_y expected %0d actual %0d", $realtime,
                           want.center_y, got.center_y);
               if (got.radius !== want.radius)
                  $display("%0t: radius expected %0d actual %0d", $realtime,
                           want.radius, got.radius);
               if (got.degenerate !== want.degenerate)
                  $display("%0t: degenerate expected %0b actual %0b", $realtime,
                           want.degenerate, got.degenerate);
               if (got.saturated !== want.saturated)
                  $display("%0t: saturated expected %0b actual %0b", $realtime,
                           want.saturated, got.saturated);
               if (got !== want) errors <= errors + 1;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Top of the circumcircle core testbench: clock, reset, register writes and point stimulus.
// Depends on ccfp_pkg, the core and circumcircle_checker, which checks every result beat.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
   import ccfp_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [THR_BITS-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic signed [15:0] req_ax = '0, req_ay = '0, req_bx = '0;
   logic signed [15:0] req_by_coord = '0, req_cx = '0, req_cy = '0;
   logic rsp_stall = 1'b0;
   wire req_stall, rsp_valid, rsp_degenerate, rsp_saturated;
   wire signed [OUT_BITS-1:0] rsp_center_x, rsp_center_y;
   wire [OUT_BITS-1:0] rsp_radius;
   int errors, pending;
   int cycles = 0;
   int hold_left = 0;
   int stall_mode = 0;
   logic hold_req = 1'b0;

   circumcircle_from_three_points_core DUT (.*);
   circumcircle_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("circumcircle_from_three_points_core test failed");
         $finish;
      end
   end

   // Receiver: a long hold when asked for, otherwise a stall pattern chosen at random and
   // changed over the run, including stretches with no stall at all.
   always @(posedge clock) begin
      if (cycles % 256 == 0) stall_mode <= $urandom_range(0, 3);
      if (hold_req && hold_left == 0) begin
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= (cycles % 5 < 2);
         endcase
      end
   end

   task automatic send_points(input logic signed [15:0] ax, ay, bx, by, cx, cy);
      logic stalled;
      req_valid <= 1'b1;
      req_ax <= ax; req_ay <= ay; req_bx <= bx;
      req_by_coord <= by; req_cx <= cx; req_cy <= cy;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
   endtask

   task automatic idle_gap();
      int gap;
      gap = $urandom_range(1, 12);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [15:0] pick_edge();
      case ($urandom_range(0, 3))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         default: return -16'sd1;
      endcase
   endfunction

   // Random triangles: half full range, some tiny, some nearly collinear, some at the edges.
   task automatic send_random_points();
      logic signed [15:0] p[6];
      int k, mode;
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
         foreach (p[i]) p[i] = 16'($urandom());
      end else if (mode < 7) begin
         foreach (p[i]) p[i] = 16'($urandom_range(0, 128) - 64);
      end else if (mode < 9) begin
         // C lies on the line through A and B, moved by at most two units in each coordinate.
         for (int i = 0; i < 4; i++) p[i] = 16'($urandom_range(0, 4000) - 2000);
         k = $urandom_range(0, 6) - 3;
         p[4] = 16'(p[0] + k * (p[2] - p[0]) + $urandom_range(0, 4) - 2);
         p[5] = 16'(p[1] + k * (p[3] - p[1]) + $urandom_range(0, 4) - 2);
      end else begin
         foreach (p[i]) p[i] = pick_edge();
      end
      send_points(p[0], p[1], p[2], p[3], p[4], p[5]);
   endtask

   initial begin
      logic [THR_BITS-1:0] thresholds[5];
      int burst;
      thresholds = '{THR_RESET, '0, '1, 37'd1 << 30, '0};
      thresholds[4] = THR_BITS'({$urandom_range(0, 31), $urandom()});
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed triangles under the reset threshold.
      send_points(0, 0, 1, 0, 0, 1);
      send_points(0, 0, 0, 0, 0, 0);
      send_points(5, 5, 5, 5, 9, -3);
      send_points(1, 2, 3, 4, 5, 6);
      send_points(-32768, -32768, 32767, -32768, -32768, 32767);
      send_points(32767, 32767, -32768, 32767, 32767, -32768);
      send_points(-32768, -32768, 32767, 32767, 32767, 32766);
      send_points(-32768, -32768, 32767, 32767, 32766, 32767);
      send_points(-32768, 32767, 32767, -32768, -32767, 32767);
      send_points(-32768, -32768, -32768, -32768, 32767, 32767);
      send_points(0, 0, 2, 1, 4, 3);
      send_points(-1, -1, -1, 0, 0, -1);
      send_points(10, 0, -10, 0, 0, 10);
      send_points(32767, 0, -32768, 0, 0, 1);
      send_points(0, -32768, 0, 32767, 1, 0);
      req_valid <= 1'b0;
      drain();

      foreach (thresholds[ph]) begin
         if (ph > 0) write_threshold(thresholds[ph]);
         for (int n = 0; n < 220; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < 220; b++, n++) begin
               if (ph == 1 && n == 20) hold_req <= 1'b1;
               else if (ph == 1 && n == 21) hold_req <= 1'b0;
               send_random_points();
            end
            idle_gap();
            if (ph == 2 && n >= 100 && n < 140) drain();
         end
         drain();
      end

      if (errors == 0) begin
         $display("circumcircle_from_three_points_core test passed");
      end else begin
         $display("circumcircle_from_three_points_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
